// ===== src/distinct_sample_hash_set_macros.svh =====
// assertion helpers shared by the sampler rtl
`ifndef DISTINCT_SAMPLE_HASH_SET_MACROS_SVH
`define DISTINCT_SAMPLE_HASH_SET_MACROS_SVH

// consequent checked in the same cycle
`define DSHS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define DSHS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/dshs_pkg.sv =====
package dshs_pkg;

   // hash input width and salt
   localparam int HASH_W = 32;
   localparam logic [HASH_W-1:0] HASH_SALT = 32'h20F7_B765;

   // remainder unit retires this many dividend bits per cycle
   localparam int REM_STEP   = 4;
   localparam int REM_CYCLES = HASH_W / REM_STEP;
   localparam int REM_CNT_W  = $clog2(REM_CYCLES);

   // configuration registers
   localparam int VC_W      = 25;
   localparam int SPN_W     = 6;
   localparam int CAPCFG_W  = 7;
   localparam int CSR_W     = 25;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLES      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY     = 2'd2;

   localparam logic [VC_W-1:0]     VERTEX_COUNT_RST = 25'd1024;
   localparam logic [SPN_W-1:0]    SAMPLES_RST      = 6'd32;
   localparam logic [CAPCFG_W-1:0] CAPACITY_RST     = 7'd64;

   // request command codes
   localparam logic CMD_START     = 1'b0;
   localparam logic CMD_CANDIDATE = 1'b1;

   localparam int KIND_W = 3;

   typedef enum logic [KIND_W-1:0] {
      KIND_STARTED  = 3'd0,
      KIND_SELF     = 3'd1,
      KIND_DUP      = 3'd2,
      KIND_INSERTED = 3'd3,
      KIND_PACKED   = 3'd4,
      KIND_RANGE    = 3'd5,
      KIND_IGNORED  = 3'd6
   } kind_type;

   // control from the sequencer to the slot store
   typedef struct packed {
      logic clear;
      logic wr_en;
   } slot_ctl_type;

endpackage

// ===== src/dshs_rem.sv =====
module dshs_rem
   import dshs_pkg::*;
#(
   parameter int DIV_W = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [HASH_W-1:0]  dividend,
   input  logic [DIV_W-1:0]   divisor,
   output logic               done,
   output logic [DIV_W-1:0]   remainder
);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [REM_CNT_W-1:0] cnt_ff, cnt_in;
   logic [HASH_W-1:0]    shift_ff, shift_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;

   logic [DIV_W:0]       trial;
   logic [DIV_W-1:0]     part;

   // restoring remainder, a few bits per cycle
   always_comb begin
      part  = rem_ff;
      trial = '0;
      for (int k = 0; k < REM_STEP; k++) begin
         trial = {part, shift_ff[HASH_W-1-k]};
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
         end
         part = trial[DIV_W-1:0];
      end
   end

   always_comb begin
      run_in   = run_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (start) begin
         run_in   = 1'b1;
         cnt_in   = '0;
         shift_in = dividend;
         rem_in   = '0;
      end else if (run_ff) begin
         rem_in   = part;
         shift_in = shift_ff << REM_STEP;
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == REM_CNT_W'(REM_CYCLES - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== src/dshs_slots.sv =====
module dshs_slots
   import dshs_pkg::*;
#(
   parameter int SLOTS  = 64,
   parameter int DATA_W = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  slot_ctl_type             ctl,
   input  logic [$clog2(SLOTS)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(SLOTS)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data,
   output logic                     rd_used
);

   logic [DATA_W-1:0] slot_mem [SLOTS];
   logic [SLOTS-1:0]  used_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_used_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   // occupancy flags, wiped at once for a new run
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= '0;
         rd_used_ff <= 1'b0;
      end else begin
         if (ctl.clear) begin
            used_ff <= '0;
         end else if (ctl.wr_en) begin
            used_ff[wr_addr] <= 1'b1;
         end
         rd_used_ff <= used_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign rd_used = rd_used_ff;

endmodule

// ===== src/distinct_sample_hash_set.sv =====
// start, ignored, self and out-of-range transactions: result in the cycle after accept, no busy.
// candidate into the table: hashing in the remainder unit (ST_HASH), then per slot probe a
//   read state and a check state (ST_PROBE_RD, ST_PROBE_CHK); busy until the result.
// completing insert: slot scan up to the capacity, packed ids in slot order, at most
//   one per cycle, busy until the last; results strobe rsp_valid, the receiver cannot stall.
// synchronous reset clears the run, occupancy flags and registers to their defaults.
`include "distinct_sample_hash_set_macros.svh"

module distinct_sample_hash_set
   import dshs_pkg::*;
#(
   parameter int MAX_SAMPLES = 32,
   parameter int TABLE_SLOTS = 64,
   parameter int ID_BITS     = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_cmd,
   input  logic [ID_BITS-1:0]   req_value,
   output logic                 busy,
   output logic                 rsp_valid,
   output logic [KIND_W-1:0]    rsp_kind,
   output logic [ID_BITS-1:0]   rsp_element,
   output logic                 rsp_last,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam int CAP_W  = $clog2(TABLE_SLOTS + 1);
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_HASH      = 5'b00010,
      ST_PROBE_RD  = 5'b00100,
      ST_PROBE_CHK = 5'b01000,
      ST_PACK      = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [VC_W-1:0]       vertex_count_ff;
   logic [SPN_W-1:0]      samples_ff;
   logic [CAPCFG_W-1:0]   capacity_ff;

   logic [ID_BITS-1:0]    own_ff, own_in;
   logic [ID_BITS-1:0]    cand_ff, cand_in;
   logic                  collecting_ff, collecting_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [SLOT_W-1:0]     pos_ff, pos_in;
   logic [CAP_W-1:0]      probe_cnt_ff, probe_cnt_in;
   logic [CAP_W-1:0]      scan_ff, scan_in;
   logic                  pk_vld_ff, pk_vld_in;
   logic [CNT_W-1:0]      emitted_ff, emitted_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              rsp_kind_ff, rsp_kind_in;
   logic [ID_BITS-1:0]    rsp_element_ff, rsp_element_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [31:0]           cap32, tgt32;
   logic [CAP_W-1:0]      cap;
   logic [CNT_W-1:0]      target;

   logic                  take;
   logic                  rem_start;
   logic                  rem_done;
   logic [CAP_W-1:0]      rem_value;
   logic [HASH_W-1:0]     hash_in;

   slot_ctl_type          slot_ctl;
   logic [SLOT_W-1:0]     rd_addr;
   logic [ID_BITS-1:0]    rd_data;
   logic                  rd_used;

   logic [CAP_W-1:0]      pos_inc;
   logic [CNT_W-1:0]      count_inc;
   logic [CNT_W-1:0]      emitted_inc;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VERTEX_COUNT_RST;
         samples_ff      <= SAMPLES_RST;
         capacity_ff     <= CAPACITY_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VERTEX_COUNT: vertex_count_ff <= csr_wdata[VC_W-1:0];
            CSR_SAMPLES:      samples_ff      <= csr_wdata[SPN_W-1:0];
            CSR_CAPACITY:     capacity_ff     <= csr_wdata[CAPCFG_W-1:0];
            default: ;
         endcase
      end
   end

   // capacity clamped to 2..slots, target to 1..max and then to capacity
   always_comb begin
      cap32 = 32'(capacity_ff);
      if (cap32 < 32'd2) begin
         cap32 = 32'd2;
      end
      if (cap32 > 32'(TABLE_SLOTS)) begin
         cap32 = 32'(TABLE_SLOTS);
      end
      tgt32 = 32'(samples_ff);
      if (tgt32 < 32'd1) begin
         tgt32 = 32'd1;
      end
      if (tgt32 > 32'(MAX_SAMPLES)) begin
         tgt32 = 32'(MAX_SAMPLES);
      end
      if (tgt32 > cap32) begin
         tgt32 = cap32;
      end
      cap    = CAP_W'(cap32);
      target = CNT_W'(tgt32);
   end

   assign busy      = (state_ff != ST_IDLE);
   assign take      = start && !busy;
   assign hash_in   = HASH_W'(req_value) ^ HASH_SALT;
   assign rem_start = take && (req_cmd == CMD_CANDIDATE) && collecting_ff
                      && (req_value != own_ff)
                      && (33'(req_value) < 33'(vertex_count_ff));

   dshs_rem #(
      .DIV_W (CAP_W)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (hash_in),
      .divisor   (cap),
      .done      (rem_done),
      .remainder (rem_value)
   );

   dshs_slots #(
      .SLOTS  (TABLE_SLOTS),
      .DATA_W (ID_BITS)
   ) u_slots (
      .clock   (clock),
      .reset   (reset),
      .ctl     (slot_ctl),
      .wr_addr (pos_ff),
      .wr_data (cand_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .rd_used (rd_used)
   );

   assign pos_inc     = CAP_W'(pos_ff) + 1'b1;
   assign count_inc   = count_ff + 1'b1;
   assign emitted_inc = emitted_ff + 1'b1;
   assign rd_addr     = (state_ff == ST_PACK) ? scan_ff[SLOT_W-1:0] : pos_ff;

   always_comb begin
      state_in       = state_ff;
      own_in         = own_ff;
      cand_in        = cand_ff;
      collecting_in  = collecting_ff;
      count_in       = count_ff;
      pos_in         = pos_ff;
      probe_cnt_in   = probe_cnt_ff;
      scan_in        = scan_ff;
      pk_vld_in      = 1'b0;
      emitted_in     = emitted_ff;
      rsp_valid_in   = 1'b0;
      rsp_kind_in    = rsp_kind_ff;
      rsp_element_in = rsp_element_ff;
      rsp_last_in    = 1'b0;
      slot_ctl       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               rsp_element_in = req_value;
               if (req_cmd == CMD_START) begin
                  own_in        = req_value;
                  count_in      = '0;
                  collecting_in = 1'b1;
                  slot_ctl.clear = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_STARTED;
               end else if (!collecting_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_IGNORED;
               end else if (req_value == own_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_SELF;
               end else if (33'(req_value) >= 33'(vertex_count_ff)) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_RANGE;
               end else begin
                  cand_in  = req_value;
                  state_in = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            if (rem_done) begin
               pos_in       = rem_value[SLOT_W-1:0];
               probe_cnt_in = '0;
               state_in     = ST_PROBE_RD;
            end
         end
         ST_PROBE_RD: begin
            state_in = ST_PROBE_CHK;
         end
         ST_PROBE_CHK: begin
            rsp_element_in = cand_ff;
            if (!rd_used) begin
               slot_ctl.wr_en = 1'b1;
               count_in       = count_inc;
               if (count_inc < target) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_INSERTED;
                  state_in     = ST_IDLE;
               end else begin
                  // run complete: scan the table in slot order
                  collecting_in = 1'b0;
                  scan_in       = '0;
                  emitted_in    = '0;
                  state_in      = ST_PACK;
               end
            end else if ((rd_data == cand_ff) || (probe_cnt_ff + 1'b1 == cap)) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_DUP;
               state_in     = ST_IDLE;
            end else begin
               pos_in       = (pos_inc == cap) ? '0 : pos_inc[SLOT_W-1:0];
               probe_cnt_in = probe_cnt_ff + 1'b1;
               state_in     = ST_PROBE_RD;
            end
         end
         ST_PACK: begin
            // one read issued per cycle, its data judged the cycle after
            if (scan_ff < cap) begin
               scan_in   = scan_ff + 1'b1;
               pk_vld_in = 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
            if (pk_vld_ff && rd_used) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = KIND_PACKED;
               rsp_element_in = rd_data;
               emitted_in     = emitted_inc;
               if (emitted_inc == target) begin
                  rsp_last_in = 1'b1;
                  pk_vld_in   = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         own_ff        <= '0;
         collecting_ff <= 1'b0;
         count_ff      <= '0;
         pk_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         own_ff        <= own_in;
         collecting_ff <= collecting_in;
         count_ff      <= count_in;
         pk_vld_ff     <= pk_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff        <= cand_in;
      pos_ff         <= pos_in;
      probe_cnt_ff   <= probe_cnt_in;
      scan_ff        <= scan_in;
      emitted_ff     <= emitted_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_element_ff <= rsp_element_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_last    = rsp_last_ff;

   `DSHS_ASSERT_SAME(a_rem_done_in_hash, rem_done, state_ff == ST_HASH, "remainder done outside hash")
   `DSHS_ASSERT_SAME(a_last_ends_run, rsp_valid_ff && rsp_last_ff, !collecting_ff, "last id while collecting")
   `DSHS_ASSERT_NEXT(a_start_opens_run, take && (req_cmd == CMD_START), collecting_ff && (count_ff == '0), "start did not open a run")

endmodule
